@@ rtl/core/dq_pkg.sv @@
// Shared types and constants for the double-ended queue.
`timescale 1ns / 1ps

package dq_pkg;

    localparam int MODE_W   = 3;
    localparam int ELEM_W   = 32;
    localparam int OCC_W    = 5;
    localparam int STATUS_W = 2;

    typedef enum logic [MODE_W-1:0] {
        MODE_INS_FRONT = 3'd0,
        MODE_INS_REAR  = 3'd1,
        MODE_REM_FRONT = 3'd2,
        MODE_REM_REAR  = 3'd3,
        MODE_LIST      = 3'd4,
        MODE_COUNT     = 3'd5
    } mode_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK    = 2'd0,
        STATUS_EMPTY = 2'd1,
        STATUS_FULL  = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_HOLD,
        ST_REMOVE,
        ST_LIST
    } state_t;

endpackage

@@ rtl/core/dq_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
`timescale 1ns / 1ps

module dq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

@@ rtl/core/double_ended_queue_top.sv @@
// Top level of the bounded double-ended queue: control, pointers and result register.
`timescale 1ns / 1ps
//
// Each request arrives as one transaction on the s_ channel: s_tuser selects the
// operation and s_tdata carries the value to insert. Results leave on the m_ channel,
// one transaction per result, with m_tlast set on the final result of a request and
// m_tuser giving the status (ok, empty, full).
// Inserts, count requests and every request that fails on an empty or full queue
// load the result register in the cycle of acceptance, so the result is offered on
// the next cycle and a new request is taken every cycle while the receiver keeps up.
// Removals first read the element from the slot RAM, which has a registered read
// port, and send it from ST_REMOVE. A list request reads one RAM entry per element,
// issuing each read while the previous entry leaves, and holds the block until the last
// entry is sent. The single read port of the slot RAM is why these steps are serial.
// A new request is taken only between requests; when the receiver stalls, the result
// register holds its transaction and further work waits for it to drain.
// Reset clears the state, the head index, the count and the result valid flag; the slot
// RAM needs no clearing because only occupied slots are ever read.
//
module double_ended_queue_top
    import dq_pkg::*;
#(
    parameter int CAPACITY = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] value
    input  logic [2:0]  s_tuser,   // [2:0] mode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [31:0] element, [36:32] occupancy, [39:37] zero
    output logic [1:0]  m_tuser,   // [1:0] status
    output logic        m_tlast
);

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);

    state_t               state_reg, state_next;
    logic [IDX_W-1:0]     front_reg, front_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [CNT_W-1:0]     list_idx_reg, list_idx_next;
    status_t              res_status_reg, res_status_next;

    logic                 m_tvalid_reg, m_tvalid_next;
    logic [ELEM_W-1:0]    m_elem_reg, m_elem_next;
    logic [OCC_W-1:0]     m_occ_reg, m_occ_next;
    status_t              m_status_reg, m_status_next;
    logic                 m_last_reg, m_last_next;

    logic                 ram_wr_en;
    logic [IDX_W-1:0]     ram_wr_addr;
    logic                 ram_rd_en;
    logic [IDX_W-1:0]     ram_rd_addr;
    logic [ELEM_W-1:0]    ram_rd_data;

    logic                 accept;
    logic                 out_free;
    logic                 full;
    logic                 empty;
    logic                 imm_valid;
    status_t              imm_status;
    logic [CNT_W-1:0]     list_idx_inc;
    logic                 list_last;

    // Ring wrap of a position known to be below twice the capacity.
    function automatic logic [IDX_W-1:0] wrap(input logic [CNT_W:0] pos);
        logic [CNT_W:0] adj;
        adj = (pos >= (CNT_W+1)'(CAPACITY)) ? pos - (CNT_W+1)'(CAPACITY) : pos;
        return adj[IDX_W-1:0];
    endfunction

    dq_ram #(
        .WIDTH (ELEM_W),
        .DEPTH (CAPACITY)
    ) u_slots (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (s_tdata),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // No transaction is taken while reset is held.
    assign s_tready     = aresetn && (state_reg == ST_IDLE);
    assign accept       = s_tvalid && s_tready;
    assign out_free     = !m_tvalid_reg || m_tready;
    assign full         = (count_reg == CNT_W'(CAPACITY));
    assign empty        = (count_reg == '0);
    assign list_idx_inc = list_idx_reg + 1'b1;
    assign list_last    = (list_idx_inc == count_reg);

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {3'b000, m_occ_reg, m_elem_reg};
    assign m_tuser  = m_status_reg;
    assign m_tlast  = m_last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            front_reg    <= '0;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            front_reg    <= front_next;
            count_reg    <= count_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        list_idx_reg   <= list_idx_next;
        res_status_reg <= res_status_next;
        m_elem_reg     <= m_elem_next;
        m_occ_reg      <= m_occ_next;
        m_status_reg   <= m_status_next;
        m_last_reg     <= m_last_next;
    end

    always_comb begin
        state_next      = state_reg;
        front_next      = front_reg;
        count_next      = count_reg;
        list_idx_next   = list_idx_reg;
        res_status_next = res_status_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        m_elem_next     = m_elem_reg;
        m_occ_next      = m_occ_reg;
        m_status_next   = m_status_reg;
        m_last_next     = m_last_reg;
        ram_wr_en       = 1'b0;
        ram_wr_addr     = front_reg;
        ram_rd_en       = 1'b0;
        ram_rd_addr     = front_reg;
        imm_valid       = 1'b0;
        imm_status      = STATUS_OK;

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    case (mode_t'(s_tuser))
                        MODE_INS_FRONT, MODE_INS_REAR: begin
                            imm_valid = 1'b1;
                            if (full) begin
                                imm_status = STATUS_FULL;
                            end else begin
                                ram_wr_en  = 1'b1;
                                count_next = count_reg + 1'b1;
                                if (mode_t'(s_tuser) == MODE_INS_FRONT) begin
                                    front_next  = (front_reg == '0) ?
                                                  IDX_W'(CAPACITY - 1) : front_reg - 1'b1;
                                    ram_wr_addr = front_next;
                                end else begin
                                    ram_wr_addr = wrap({1'b0, CNT_W'(front_reg)} +
                                                       {1'b0, count_reg});
                                end
                            end
                        end
                        MODE_REM_FRONT, MODE_REM_REAR: begin
                            if (empty) begin
                                imm_valid  = 1'b1;
                                imm_status = STATUS_EMPTY;
                            end else begin
                                // The slot is read here and sent from ST_REMOVE;
                                // no write can reach the RAM in between.
                                ram_rd_en  = 1'b1;
                                count_next = count_reg - 1'b1;
                                state_next = ST_REMOVE;
                                if (mode_t'(s_tuser) == MODE_REM_FRONT) begin
                                    ram_rd_addr = front_reg;
                                    front_next  = wrap({1'b0, CNT_W'(front_reg)} + 1'b1);
                                end else begin
                                    ram_rd_addr = wrap({1'b0, CNT_W'(front_reg)} +
                                                       {1'b0, count_next});
                                end
                            end
                        end
                        MODE_LIST: begin
                            if (empty) begin
                                imm_valid  = 1'b1;
                                imm_status = STATUS_EMPTY;
                            end else begin
                                ram_rd_en     = 1'b1;
                                ram_rd_addr   = front_reg;
                                list_idx_next = '0;
                                state_next    = ST_LIST;
                            end
                        end
                        default: begin
                            imm_valid = 1'b1;
                        end
                    endcase

                    if (imm_valid) begin
                        if (out_free) begin
                            m_tvalid_next = 1'b1;
                            m_elem_next   = '0;
                            m_occ_next    = OCC_W'(count_next);
                            m_status_next = imm_status;
                            m_last_next   = 1'b1;
                        end else begin
                            res_status_next = imm_status;
                            state_next      = ST_HOLD;
                        end
                    end
                end
            end
            ST_HOLD: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_elem_next   = '0;
                    m_occ_next    = OCC_W'(count_reg);
                    m_status_next = res_status_reg;
                    m_last_next   = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            ST_REMOVE: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_elem_next   = ram_rd_data;
                    m_occ_next    = OCC_W'(count_reg);
                    m_status_next = STATUS_OK;
                    m_last_next   = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            ST_LIST: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_elem_next   = ram_rd_data;
                    m_occ_next    = OCC_W'(count_reg);
                    m_status_next = STATUS_OK;
                    m_last_next   = list_last;
                    if (list_last) begin
                        state_next = ST_IDLE;
                    end else begin
                        // Fetch the next entry while this one leaves.
                        ram_rd_en     = 1'b1;
                        ram_rd_addr   = wrap({1'b0, CNT_W'(front_reg)} +
                                             {1'b0, list_idx_inc});
                        list_idx_next = list_idx_inc;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(CAPACITY))
        else $error("occupancy exceeds capacity");

    a_front_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        front_reg < IDX_W'(CAPACITY - 1) || front_reg == IDX_W'(CAPACITY - 1))
        else $error("head index outside the ring");

    a_list_index: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_LIST |-> list_idx_reg < count_reg)
        else $error("list walk beyond the stored entries");

    a_write_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_wr_en |-> (accept && !full))
        else $error("slot write outside an accepted insert");

    a_insert_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && ram_wr_en) |=> count_reg == $past(count_reg) + 1'b1)
        else $error("insert did not raise the occupancy");
`endif

endmodule
